[sv/lpbw_pkg.sv]
// shared constants, types and helpers of the led panel bit-plane pixel writer
package lpbw_pkg;

	localparam int CHAIN_COUNT = 3;
	localparam int PANEL_ROWS = 32;
	localparam int PANEL_COLS = 64;
	localparam int HALF_ROWS = 16;
	localparam int PLANE_COUNT = 16;
	localparam int SCAN_GROUPS = 8;
	localparam int COLS_PER_GROUP = 16;

	localparam int SLOT_COUNT = PANEL_COLS * HALF_ROWS * CHAIN_COUNT;
	localparam int STORE_WORDS = SLOT_COUNT * PLANE_COUNT;
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int ADDR_W = SLOT_W + $clog2(PLANE_COUNT);
	localparam int WORD_W = 6;
	localparam int VISIBLE_X = CHAIN_COUNT * PANEL_ROWS;

	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_FILL = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// mapped pixel location handed from the slot mapper to the sequencer
	typedef struct packed {
		logic in_range;
		logic lower_half;
		logic [SLOT_W-1:0] slot;
	} slot_info_t;

	// rgb bits of one plane, plane 0 takes bit 15
	function automatic logic [2:0] plane_rgb(input logic [15:0] r, input logic [15:0] g,
		input logic [15:0] b, input logic [3:0] plane);
		logic [3:0] bit_idx;
		bit_idx = ~plane;
		return {b[bit_idx], g[bit_idx], r[bit_idx]};
	endfunction

endpackage

[sv/lpbw_ram.sv]
// generic simple dual-port ram with registered read data
module lpbw_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/lpbw_slot_map.sv]
// rotation of visible coordinates into the scrambled panel slot
module lpbw_slot_map (
	input  logic [6:0]               pixel_x,
	input  logic [5:0]               pixel_y,
	output lpbw_pkg::slot_info_t     info
);

	logic [4:0] mrow;
	logic [1:0] panel;
	logic [2:0] row_group;
	logic [2:0] col_group;
	logic [31:0] prefix;

	always_comb begin
		// matrix row counts down from the panel edge
		mrow = ~pixel_x[4:0];
		panel = pixel_x[6:5];
		row_group = mrow[2:0];
		col_group = {~mrow[3], pixel_y[5:4]};
		prefix = 32'({row_group, pixel_y[3:0]}) * 32'(lpbw_pkg::CHAIN_COUNT) + 32'(panel);
		info.in_range = 32'(pixel_x) < 32'(lpbw_pkg::VISIBLE_X);
		info.lower_half = mrow[4];
		info.slot = {prefix[lpbw_pkg::SLOT_W-4:0], col_group};
	end

endmodule

[sv/led_panel_bitplane_pixel_writer_top.sv]
// top level of the led panel bit-plane pixel writer: sequencer around the plane store
//
// The plane store holds 16 six-bit words per pixel slot (upper-half rgb in bits 2:0,
// lower-half rgb in bits 5:3), one word per bit plane, in a single simple dual-port ram
// with a registered read. After reset a clearing pass writes zero to every word, one
// word a cycle (49152 words with three panels), with in_stall high throughout.
// A pixel write is accepted and then runs 17 steps: sixteen plane words are read,
// merged with the new three colour bits of their half and written back, the write of
// one plane overlapping the read of the next. Out-of-range pixels and the unused kind
// are accepted and change nothing. A fill writes every word, one a cycle. A read waits
// in ST_READ while the previous result still waits on out_stall, and leaves its word in
// the output register; an address beyond the store reads zero.
// Only one transfer is worked on at a time, set by the single ram write port.
module led_panel_bitplane_pixel_writer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [6:0]  pixel_x,
	input  logic [5:0]  pixel_y,
	input  logic [15:0] red_level,
	input  logic [15:0] green_level,
	input  logic [15:0] blue_level,
	input  logic [15:0] word_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  read_bits
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PIXEL,
		ST_FILL,
		ST_READ
	} state_t;

	localparam logic [lpbw_pkg::ADDR_W-1:0] LAST_ADDR =
		lpbw_pkg::ADDR_W'(lpbw_pkg::STORE_WORDS - 1);

	state_t state_q;
	logic [lpbw_pkg::ADDR_W-1:0] addr_q;        // sweep address for clear and fill
	logic [4:0] plane_q;                        // pixel write step, 0..16
	logic [lpbw_pkg::SLOT_W-1:0] slot_q;
	logic lower_q;
	logic [15:0] red_q;
	logic [15:0] green_q;
	logic [15:0] blue_q;
	logic rd_zero_q;
	logic out_valid_q;
	logic [5:0] out_bits_q;

	lpbw_pkg::slot_info_t info;
	logic accept;
	logic rd_in_range;
	logic [31:0] word_addr_wide;
	logic [3:0] wr_plane;
	logic [2:0] wr_rgb;
	logic [2:0] fill_rgb;

	logic ram_we;
	logic [lpbw_pkg::ADDR_W-1:0] ram_waddr;
	logic [5:0] ram_wdata;
	logic ram_re;
	logic [lpbw_pkg::ADDR_W-1:0] ram_raddr;
	logic [5:0] ram_rdata;

	lpbw_slot_map u_slot_map (
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.info    (info)
	);

	lpbw_ram #(
		.DEPTH (lpbw_pkg::STORE_WORDS),
		.WIDTH (lpbw_pkg::WORD_W),
		.AW    (lpbw_pkg::ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// one transfer in flight at a time
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;

	always_comb begin
		word_addr_wide = 32'(word_address);
		rd_in_range = word_addr_wide < 32'(lpbw_pkg::STORE_WORDS);

		// plane written in this step is the one read in the step before
		wr_plane = plane_q[3:0] - 4'd1;
		wr_rgb = lpbw_pkg::plane_rgb(red_q, green_q, blue_q, wr_plane);
		// word offset within a slot is the plane with its low bit flipped
		fill_rgb = lpbw_pkg::plane_rgb(red_q, green_q, blue_q, addr_q[3:0] ^ 4'd1);

		ram_re = 1'b0;
		ram_raddr = word_addr_wide[lpbw_pkg::ADDR_W-1:0];
		ram_we = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;

		case (state_q)
			ST_IDLE: begin
				ram_re = accept && (kind == lpbw_pkg::KIND_READ) && rd_in_range;
			end
			ST_PIXEL: begin
				ram_re = !plane_q[4];
				ram_raddr = {slot_q, plane_q[3:0] ^ 4'd1};
				ram_we = (plane_q != 5'd0);
				ram_waddr = {slot_q, wr_plane ^ 4'd1};
				// keep the other half of the word
				ram_wdata = lower_q ? {wr_rgb, ram_rdata[2:0]} : {ram_rdata[5:3], wr_rgb};
			end
			ST_FILL: begin
				ram_we = 1'b1;
				ram_wdata = {fill_rgb, fill_rgb};
			end
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q <= '0;
			plane_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result leaves on its transfer, a read step reloads it itself
			if (out_valid_q && !out_stall && state_q != ST_READ) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							lpbw_pkg::KIND_PIXEL: begin
								if (info.in_range) begin
									slot_q <= info.slot;
									lower_q <= info.lower_half;
									red_q <= red_level;
									green_q <= green_level;
									blue_q <= blue_level;
									plane_q <= '0;
									state_q <= ST_PIXEL;
								end
							end
							lpbw_pkg::KIND_FILL: begin
								red_q <= red_level;
								green_q <= green_level;
								blue_q <= blue_level;
								addr_q <= '0;
								state_q <= ST_FILL;
							end
							lpbw_pkg::KIND_READ: begin
								rd_zero_q <= !rd_in_range;
								state_q <= ST_READ;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PIXEL: begin
					plane_q <= plane_q + 5'd1;
					if (plane_q[4]) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FILL: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					// ram data holds until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_bits_q <= rd_zero_q ? 6'd0 : ram_rdata;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign read_bits = out_bits_q;

endmodule
